/* rtl/lpi_pkg.sv */
// lpi_pkg: shared constants and the pipeline control struct of the line pair intersection core
// no dependencies; imported by every module of the core
package lpi_pkg;

    localparam int COORD_BITS_DEF = 24;

    // parallel threshold register
    localparam int THR_BITS = 24;
    localparam logic [THR_BITS-1:0] THR_RESET = 24'd1678;

    // Q16.16 result and the quotient that feeds it
    localparam int OUT_BITS  = 32;
    localparam int OUT_FRAC  = 16;
    localparam int QUO_BITS  = OUT_BITS + 1;
    localparam int PRE_SHIFT = QUO_BITS - OUT_FRAC;

    localparam logic [OUT_BITS-1:0] POS_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] NEG_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    typedef struct packed {
        logic valid;
        logic parallel;
        logic neg_u;
        logic neg_v;
        logic ovf_u;
        logic ovf_v;
    } t_ctrl;

endpackage

/* rtl/lpi_front.sv */
// lpi_front: differences, cross products and sums (three register stages)
// depends on lpi_pkg
module lpi_front import lpi_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DW = COORD_BITS + 1,
    localparam int PW = 2 * DW,
    localparam int SW = PW + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_ux0,
    input  logic signed [COORD_BITS-1:0] i_uy0,
    input  logic signed [COORD_BITS-1:0] i_ux1,
    input  logic signed [COORD_BITS-1:0] i_uy1,
    input  logic signed [COORD_BITS-1:0] i_vx0,
    input  logic signed [COORD_BITS-1:0] i_vy0,
    input  logic signed [COORD_BITS-1:0] i_vx1,
    input  logic signed [COORD_BITS-1:0] i_vy1,
    output logic                         o_valid,
    output logic signed [SW-1:0]         o_den,
    output logic signed [SW-1:0]         o_num_u,
    output logic signed [SW-1:0]         o_num_v
);

    logic [2:0] r_vld;

    logic signed [DW-1:0] r_dux, r_duy, r_dvx, r_dvy, r_ox, r_oy;
    logic signed [PW-1:0] r_p_d0, r_p_d1, r_p_u0, r_p_u1, r_p_v0, r_p_v1;
    logic signed [SW-1:0] r_den, r_num_u, r_num_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // directions and offset between start points
        r_dux <= DW'(i_ux1) - DW'(i_ux0);
        r_duy <= DW'(i_uy1) - DW'(i_uy0);
        r_dvx <= DW'(i_vx1) - DW'(i_vx0);
        r_dvy <= DW'(i_vy1) - DW'(i_vy0);
        r_ox  <= DW'(i_ux0) - DW'(i_vx0);
        r_oy  <= DW'(i_uy0) - DW'(i_vy0);
        // six exact products
        r_p_d0 <= r_dvy * r_dux;
        r_p_d1 <= r_dvx * r_duy;
        r_p_u0 <= r_dvx * r_oy;
        r_p_u1 <= r_dvy * r_ox;
        r_p_v0 <= r_dux * r_oy;
        r_p_v1 <= r_duy * r_ox;
        // cross product sums
        r_den   <= SW'(r_p_d0) - SW'(r_p_d1);
        r_num_u <= SW'(r_p_u0) - SW'(r_p_u1);
        r_num_v <= SW'(r_p_v0) - SW'(r_p_v1);
    end

    assign o_valid = r_vld[2];
    assign o_den   = r_den;
    assign o_num_u = r_num_u;
    assign o_num_v = r_num_v;

endmodule

/* rtl/lpi_div_step.sv */
// lpi_div_step: one restoring division step for both quotient lanes, registered
// depends on lpi_pkg
module lpi_div_step import lpi_pkg::*; #(
    parameter int SW = 2 * (COORD_BITS_DEF + 1) + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_ctrl                          i_ctrl,
    input  logic [SW-1:0]                  i_dmag,
    input  logic [1:0][SW-1:0]             i_rem,
    input  logic [1:0][PRE_SHIFT-1:0]      i_low,
    input  logic [1:0][QUO_BITS-1:0]       i_quo,
    output t_ctrl                          o_ctrl,
    output logic [SW-1:0]                  o_dmag,
    output logic [1:0][SW-1:0]             o_rem,
    output logic [1:0][PRE_SHIFT-1:0]      o_low,
    output logic [1:0][QUO_BITS-1:0]       o_quo
);

    t_ctrl                      r_ctrl;
    logic [SW-1:0]              r_dmag;
    logic [1:0][SW-1:0]         r_rem, n_rem;
    logic [1:0][PRE_SHIFT-1:0]  r_low, n_low;
    logic [1:0][QUO_BITS-1:0]   r_quo, n_quo;

    always_comb begin
        logic [SW:0]   trial;
        logic [SW+1:0] diff;
        logic          ge;
        for (int l = 0; l < 2; l++) begin
            trial = {i_rem[l], i_low[l][PRE_SHIFT-1]};
            diff  = {1'b0, trial} - {2'b00, i_dmag};
            ge    = ~diff[SW+1];
            n_rem[l] = ge ? diff[SW-1:0] : trial[SW-1:0];
            n_quo[l] = {i_quo[l][QUO_BITS-2:0], ge};
            n_low[l] = {i_low[l][PRE_SHIFT-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dmag <= i_dmag;
        r_rem  <= n_rem;
        r_low  <= n_low;
        r_quo  <= n_quo;
    end

    assign o_ctrl = r_ctrl;
    assign o_dmag = r_dmag;
    assign o_rem  = r_rem;
    assign o_low  = r_low;
    assign o_quo  = r_quo;

endmodule

/* rtl/line_pair_intersection_core.sv */
// line_pair_intersection_core: top level, classification, divider chain and result stage
// depends on lpi_pkg, lpi_front, lpi_div_step
//
// throughput: one request per clock, busy is never raised; 33 one-bit divider steps set depth
// reset: synchronous active low, clears all valid bits and loads the threshold with its default
// the receiver cannot stall: each result is shown for exactly one cycle with o_done high
module line_pair_intersection_core import lpi_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_first_start_x,
    input  logic signed [COORD_BITS-1:0] i_first_start_y,
    input  logic signed [COORD_BITS-1:0] i_first_end_x,
    input  logic signed [COORD_BITS-1:0] i_first_end_y,
    input  logic signed [COORD_BITS-1:0] i_second_start_x,
    input  logic signed [COORD_BITS-1:0] i_second_start_y,
    input  logic signed [COORD_BITS-1:0] i_second_end_x,
    input  logic signed [COORD_BITS-1:0] i_second_end_y,
    // threshold register write
    input  logic                         i_cfg_we,
    input  logic [THR_BITS-1:0]          i_cfg_wdata,
    // result channel
    output logic                         o_done,
    output logic                         o_hit,
    output logic signed [OUT_BITS-1:0]   o_pos_on_first,
    output logic signed [OUT_BITS-1:0]   o_pos_on_second,
    output logic                         o_saturated
);

    localparam int DW = COORD_BITS + 1;
    localparam int SW = 2 * DW + 1;
    // width for the threshold compare, covers both operands
    localparam int CW = (SW > THR_BITS) ? SW : THR_BITS;

    // ------------------------------------------------------------------
    // threshold register
    // ------------------------------------------------------------------
    logic [THR_BITS-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // fully pipelined, a request is taken every cycle
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // stages 1..3: differences, products, cross sums
    // ------------------------------------------------------------------
    logic                 f_valid;
    logic signed [SW-1:0] f_den, f_num_u, f_num_v;

    lpi_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_ux0   (i_first_start_x),
        .i_uy0   (i_first_start_y),
        .i_ux1   (i_first_end_x),
        .i_uy1   (i_first_end_y),
        .i_vx0   (i_second_start_x),
        .i_vy0   (i_second_start_y),
        .i_vx1   (i_second_end_x),
        .i_vy1   (i_second_end_y),
        .o_valid (f_valid),
        .o_den   (f_den),
        .o_num_u (f_num_u),
        .o_num_v (f_num_v)
    );

    // ------------------------------------------------------------------
    // stage 4: magnitudes and signs
    // ------------------------------------------------------------------
    logic          r_abs_valid;
    logic [SW-1:0] r_dmag, r_nmag_u, r_nmag_v;
    logic          r_sd, r_su, r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_valid <= 1'b0;
        end else begin
            r_abs_valid <= f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        // most negative value maps onto its own bit pattern, which is the right magnitude
        r_dmag   <= f_den[SW-1]   ? (~f_den + 1'b1)   : f_den;
        r_nmag_u <= f_num_u[SW-1] ? (~f_num_u + 1'b1) : f_num_u;
        r_nmag_v <= f_num_v[SW-1] ? (~f_num_v + 1'b1) : f_num_v;
        r_sd     <= f_den[SW-1];
        r_su     <= f_num_u[SW-1];
        r_sv     <= f_num_v[SW-1];
    end

    // ------------------------------------------------------------------
    // stage 5: parallel test and quotient overflow precheck
    // quotient is floor(|n| * 2^16 / |d|); it needs more than QUO_BITS bits
    // exactly when (|n| >> PRE_SHIFT) >= |d|, otherwise that value seeds the remainder
    // ------------------------------------------------------------------
    logic [SW-1:0] pre_u, pre_v;
    t_ctrl         n_pre_ctrl;

    assign pre_u = r_nmag_u >> PRE_SHIFT;
    assign pre_v = r_nmag_v >> PRE_SHIFT;

    always_comb begin
        n_pre_ctrl.valid    = r_abs_valid;
        // zero denominator always counts as parallel, also at a zero threshold
        n_pre_ctrl.parallel = (r_dmag == '0) || (CW'(r_dmag) < CW'(r_thr));
        n_pre_ctrl.neg_u    = r_su ^ r_sd;
        n_pre_ctrl.neg_v    = r_sv ^ r_sd;
        n_pre_ctrl.ovf_u    = pre_u >= r_dmag;
        n_pre_ctrl.ovf_v    = pre_v >= r_dmag;
    end

    t_ctrl                      w_ctrl [QUO_BITS+1];
    logic [SW-1:0]              w_dmag [QUO_BITS+1];
    logic [1:0][SW-1:0]         w_rem  [QUO_BITS+1];
    logic [1:0][PRE_SHIFT-1:0]  w_low  [QUO_BITS+1];
    logic [1:0][QUO_BITS-1:0]   w_quo  [QUO_BITS+1];

    t_ctrl                      r_pre_ctrl;
    logic [SW-1:0]              r_pre_dmag;
    logic [1:0][SW-1:0]         r_pre_rem;
    logic [1:0][PRE_SHIFT-1:0]  r_pre_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_ctrl <= '0;
        end else begin
            r_pre_ctrl <= n_pre_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pre_dmag   <= r_dmag;
        r_pre_rem[0] <= pre_u;
        r_pre_rem[1] <= pre_v;
        // low numerator bits feed the divider one per step, zeros follow for the fraction
        r_pre_low[0] <= r_nmag_u[PRE_SHIFT-1:0];
        r_pre_low[1] <= r_nmag_v[PRE_SHIFT-1:0];
    end

    assign w_ctrl[0] = r_pre_ctrl;
    assign w_dmag[0] = r_pre_dmag;
    assign w_rem[0]  = r_pre_rem;
    assign w_low[0]  = r_pre_low;
    assign w_quo[0]  = '0;

    // ------------------------------------------------------------------
    // stages 6..38: one quotient bit per stage for both lanes, msb first
    // ------------------------------------------------------------------
    for (genvar s = 0; s < QUO_BITS; s++) begin : g_div
        lpi_div_step #(
            .SW (SW)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[s]),
            .i_dmag  (w_dmag[s]),
            .i_rem   (w_rem[s]),
            .i_low   (w_low[s]),
            .i_quo   (w_quo[s]),
            .o_ctrl  (w_ctrl[s+1]),
            .o_dmag  (w_dmag[s+1]),
            .o_rem   (w_rem[s+1]),
            .o_low   (w_low[s+1]),
            .o_quo   (w_quo[s+1])
        );
    end

    // ------------------------------------------------------------------
    // stage 39: sign, saturation, parallel override, result register
    // ------------------------------------------------------------------
    t_ctrl                     e_ctrl;
    logic [1:0][OUT_BITS-1:0]  n_pos;
    logic [1:0]                n_sat_lane;
    logic                      n_hit, n_sat;

    assign e_ctrl = w_ctrl[QUO_BITS];

    always_comb begin
        logic [1:0]          neg, ovf;
        logic [QUO_BITS-1:0] q;
        logic                sat_p, sat_n;
        neg = {e_ctrl.neg_v, e_ctrl.neg_u};
        ovf = {e_ctrl.ovf_v, e_ctrl.ovf_u};
        for (int l = 0; l < 2; l++) begin
            q     = w_quo[QUO_BITS][l];
            // positive side tops out at 2^31-1, negative side reaches -2^31
            sat_p = ovf[l] | q[QUO_BITS-1] | q[QUO_BITS-2];
            sat_n = ovf[l] | q[QUO_BITS-1] | (q[QUO_BITS-2] & (|q[QUO_BITS-3:0]));
            if (neg[l]) begin
                n_sat_lane[l] = sat_n;
                n_pos[l]      = sat_n ? NEG_MIN : (~q[OUT_BITS-1:0] + 1'b1);
            end else begin
                n_sat_lane[l] = sat_p;
                n_pos[l]      = sat_p ? POS_MAX : q[OUT_BITS-1:0];
            end
        end
        n_hit = ~e_ctrl.parallel;
        n_sat = n_hit & (|n_sat_lane);
        if (!n_hit) begin
            n_pos = '0;
        end
    end

    logic                r_done;
    logic                r_hit, r_sat;
    logic [OUT_BITS-1:0] r_pos_u, r_pos_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= e_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit   <= n_hit;
        r_sat   <= n_sat;
        r_pos_u <= n_pos[0];
        r_pos_v <= n_pos[1];
    end

    assign o_done          = r_done;
    assign o_hit           = r_hit;
    assign o_pos_on_first  = r_pos_u;
    assign o_pos_on_second = r_pos_v;
    assign o_saturated     = r_sat;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // parallel results carry zeros and no saturation
    a_parallel_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_hit |-> o_pos_on_first == '0 && o_pos_on_second == '0 && !o_saturated)
        else $error("parallel result with nonzero payload");

    // a saturated result has at least one lane pinned at a range limit
    a_sat_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_saturated |->
            o_pos_on_first == POS_MAX || o_pos_on_first == NEG_MIN ||
            o_pos_on_second == POS_MAX || o_pos_on_second == NEG_MIN)
        else $error("saturation flag without a clipped lane");

    // after the last step the remainder stays below the divisor on lanes that did not overflow
    a_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        e_ctrl.valid |->
            (e_ctrl.ovf_u || w_rem[QUO_BITS][0] < w_dmag[QUO_BITS]) &&
            (e_ctrl.ovf_v || w_rem[QUO_BITS][1] < w_dmag[QUO_BITS]))
        else $error("divider remainder out of range");

    // the result strobe follows the precheck register valid through the divider steps and the result register
    a_done_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pre_ctrl.valid |-> ##(QUO_BITS+1) o_done)
        else $error("request lost in the divider chain");

endmodule
